/* design/pid_position_delta_controller_unit_defines.svh */
// Assertion macros shared by the checker of the PID controller block.
`ifndef PID_POSITION_DELTA_CONTROLLER_UNIT_DEFINES_SVH
`define PID_POSITION_DELTA_CONTROLLER_UNIT_DEFINES_SVH
// Asserts that an antecedent implies a consequent in the next cycle.
`define PDC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
// Asserts that an antecedent implies a consequent in the same cycle.
`define PDC_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

/* design/pdc_pkg.sv */
// Types and constants shared by the PID controller block.
`timescale 1ns / 1ps
package pdc_pkg;
  localparam int unsigned SigW = 32;
  localparam int unsigned GainW = 24;
  localparam int unsigned LimW = 31;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainP = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainI = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainD = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutLim = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIntLim = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInDb = 3'd6;
  localparam logic [CfgIdxW-1:0] RegRejLim = 3'd7;
  localparam logic [16:0] WSmoothNew = 17'd45875;
  localparam logic [16:0] WSmoothOld = 17'd19661;
  localparam logic signed [63:0] SatMax = 64'sd2147483647;
  localparam logic signed [63:0] SatMin = -64'sd2147483648;
endpackage

/* design/pdc_serial_mul.sv */
// Shift-and-add signed multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module pdc_serial_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [33:0]  mcand,
  input  logic signed [33:0]  mplier,
  output logic                done,
  output logic signed [67:0]  product
);
  import pdc_pkg::*;
  logic [5:0] count;
  logic busy;
  logic signed [67:0] acc;
  logic signed [67:0] cand;
  logic [33:0] bits;
  logic signed [67:0] addend;

  // The top multiplier bit carries negative weight.
  always_comb begin
    addend = bits[0] ? cand : 68'sd0;
    if (count == 6'd33) begin
      addend = -addend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd0;
        acc <= 68'sd0;
        cand <= 68'(mcand);
        bits <= mplier;
      end else if (busy) begin
        acc <= acc + addend;
        cand <= cand <<< 1;
        bits <= bits >> 1;
        count <= count + 6'd1;
        if (count == 6'd33) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign product = acc;
endmodule

/* design/pid_position_delta_controller_unit.sv */
// Top level of the PID controller: register file, sequencer and result register.
//
// Input beats carry kind, measured, target and smooth on in_valid/in_ready;
// result beats carry drive and rejected on out_valid/out_ready. Registers
// are written through cfg_we/cfg_index/cfg_data with no wait.
// One item is worked at a time. A compute item runs its products through one
// shared shift-and-add multiplier: P, I and D, with two more in front when
// smoothing. out_valid rises at the edge that takes the beat for a clear item;
// a compute item goes on through S_SUM and S_OUT after the products, and a
// rejected error ends after the check. The next beat can be taken in the cycle
// after the result is taken.
// The result sits in an output register; in_ready is low while a result
// waits, so a stalled receiver holds the block with its state intact.
// Reset clears the config registers, error history, integral, output accumulator and out_valid.
`timescale 1ns / 1ps
module pid_position_delta_controller_unit #(
  parameter logic [30:0] DRIVE_DEAD_ZONE = 31'd0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [31:0] measured,
  input  logic signed [31:0] target,
  input  logic               smooth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive,
  output logic               rejected,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import pdc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SM1, S_SM2, S_CHECK, S_MP, S_MI, S_MD, S_SUM, S_OUT
  } state_t;

  state_t state;
  logic mode;
  logic signed [23:0] gain_p, gain_i, gain_d;
  logic [30:0] output_limit, integ_cap, db_window, error_reject_limit;
  logic signed [31:0] last_error, older_error, integral_term, output_accum;
  logic signed [32:0] raw;
  logic signed [31:0] err;
  logic smoothed;
  logic signed [63:0] sm_first;
  logic signed [31:0] p_term, i_term;
  logic mul_start, mul_done;
  logic signed [33:0] mcand, mplier;
  logic signed [67:0] product;
  logic signed [33:0] d1, d2;
  logic signed [63:0] shifted, sat_in;
  logic signed [31:0] sat_prod;
  logic signed [63:0] sum_pos, sum_inc, int_sum;
  logic signed [31:0] out_clamped, int_clamped;

  function automatic logic signed [31:0] sat_fn(input logic signed [63:0] v);
    if (v > SatMax) begin
      return 32'sh7fffffff;
    end else if (v < SatMin) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_fn(input logic signed [63:0] v,
                                                 input logic [30:0] lim);
    logic signed [63:0] l;
    l = 64'(lim);
    if (v > l) begin
      return l[31:0];
    end else if (v < -l) begin
      return 32'(-l);
    end
    return v[31:0];
  endfunction

  assign d1 = 34'(err) - 34'(last_error);
  assign d2 = 34'(err) - (34'(last_error) <<< 1) + 34'(older_error);
  // Arithmetic shift floors, matching the dropped low bits.
  assign shifted = 64'(product >>> 16);
  assign sat_in = shifted;
  assign sat_prod = sat_fn(sat_in);
  assign int_sum = 64'(integral_term) + 64'(sat_prod);
  assign int_clamped = clamp_fn(64'(sat_fn(int_sum)), integ_cap);
  assign sum_pos = 64'(p_term) + 64'(integral_term) + 64'(sat_prod);
  assign sum_inc = 64'(output_accum) + 64'(p_term) + 64'(i_term) + 64'(sat_prod);
  assign out_clamped = clamp_fn(64'(sat_fn(mode ? sum_inc : sum_pos)), output_limit);

  pdc_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mcand),
    .mplier  (mplier),
    .done    (mul_done),
    .product (product)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      smoothed <= 1'b0;
      mode <= 1'b0;
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      output_limit <= '0;
      integ_cap <= '0;
      db_window <= '0;
      error_reject_limit <= '0;
      last_error <= '0;
      older_error <= '0;
      integral_term <= '0;
      output_accum <= '0;
    end else begin
      mul_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          RegMode: mode <= cfg_data[0];
          RegGainP: gain_p <= cfg_data[23:0];
          RegGainI: gain_i <= cfg_data[23:0];
          RegGainD: gain_d <= cfg_data[23:0];
          RegOutLim: output_limit <= cfg_data;
          RegIntLim: integ_cap <= cfg_data;
          RegInDb: db_window <= cfg_data;
          RegRejLim: error_reject_limit <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (kind) begin
              integral_term <= '0;
              output_accum <= '0;
              drive <= '0;
              rejected <= 1'b0;
              out_valid <= 1'b1;
            end else begin
              raw <= 33'(target) - 33'(measured);
              smoothed <= smooth;
              if (smooth) begin
                // The 0.7 weighting of the new error starts at once.
                mcand <= 34'(target) - 34'(measured);
                mplier <= 34'(WSmoothNew);
                mul_start <= 1'b1;
                state <= S_SM1;
              end else begin
                state <= S_CHECK;
              end
            end
          end
        end
        S_SM1: begin
          if (mul_done) begin
            sm_first <= 64'(product >>> 16);
            mcand <= 34'(last_error);
            mplier <= 34'(WSmoothOld);
            mul_start <= 1'b1;
            state <= S_SM2;
          end
        end
        S_SM2: begin
          if (mul_done) begin
            err <= sat_fn(sm_first + 64'(product >>> 16));
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          logic signed [31:0] e;
          logic signed [32:0] m;
          // The deadband looks at the exact difference, smoothed or not.
          if (db_window != 31'd0 &&
              (raw < 0 ? -raw : raw) <= 33'(db_window)) begin
            e = '0;
            integral_term <= '0;
          end else if (smoothed) begin
            e = err;
          end else if (raw > 33'sh0_7fffffff) begin
            e = 32'sh7fffffff;
          end else if (raw < -33'sh0_80000000) begin
            e = 32'sh80000000;
          end else begin
            e = raw[31:0];
          end
          err <= e;
          m = (e < 0) ? -33'(e) : 33'(e);
          if (error_reject_limit != 31'd0 && m > 33'(error_reject_limit)) begin
            drive <= '0;
            rejected <= 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            mcand <= 34'(gain_p);
            mplier <= mode ? (34'(e) - 34'(last_error)) : 34'(e);
            mul_start <= 1'b1;
            state <= S_MP;
          end
        end
        S_MP: begin
          if (mul_done) begin
            p_term <= sat_prod;
            mcand <= 34'(gain_i);
            mplier <= 34'(err);
            mul_start <= 1'b1;
            state <= S_MI;
          end
        end
        S_MI: begin
          if (mul_done) begin
            if (mode) begin
              i_term <= sat_prod;
              integral_term <= sat_prod;
            end else begin
              integral_term <= int_clamped;
            end
            mcand <= 34'(gain_d);
            mplier <= mode ? d2 : d1;
            mul_start <= 1'b1;
            state <= S_MD;
          end
        end
        S_MD: begin
          if (mul_done) begin
            output_accum <= out_clamped;
            older_error <= last_error;
            last_error <= err;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (DRIVE_DEAD_ZONE != 31'd0 &&
              ((output_accum < 0) ? -33'(output_accum) : 33'(output_accum))
                < 33'(DRIVE_DEAD_ZONE)) begin
            drive <= '0;
          end else begin
            drive <= output_accum;
          end
          rejected <= 1'b0;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/pdc_checker.sv */
// Port-level checker for the PID controller, bound to the top level.
`timescale 1ns / 1ps
`include "pid_position_delta_controller_unit_defines.svh"
module pdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] drive,
  input logic        rejected
);
  // A rejected beat always reports zero drive.
  `PDC_ASSERT_NOW(a_rej_zero, clk, rst, out_valid && rejected, drive == 32'd0)
  // A waiting result holds until taken.
  `PDC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(drive))
  // A clear beat produces a zero result at once.
  `PDC_ASSERT_NEXT(a_clear, clk, rst, in_valid && in_ready && kind,
    out_valid && drive == 32'd0 && !rejected)
  // No new item is taken while a result waits.
  `PDC_ASSERT_NOW(a_block, clk, rst, out_valid, !in_ready)
endmodule

bind pid_position_delta_controller_unit pdc_checker u_pdc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
  .out_valid(out_valid), .out_ready(out_ready), .drive(drive), .rejected(rejected)
);

/* tb/pid_position_delta_controller_unit_test.sv */
// Self-checking testbench of the PID controller block, positional and incremental modes.
`timescale 1ns / 1ps
module pid_position_delta_controller_unit_test;
  import pdc_pkg::*;

  localparam longint OutDeadband = 0;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic signed [31:0] drive;
    logic               rejected;
  } drive_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic signed [31:0] measured = '0;
  logic signed [31:0] target = '0;
  logic smooth = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] drive;
  logic rejected;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  // Predictor copy of the registers and the controller state.
  logic   mode_cfg;
  longint kp, ki, kd, out_lim, int_lim, in_db, rej_lim;
  longint last_err, older_err, integ, accum;

  drive_beat_t expected_drives[$];
  int errors = 0;
  int cycles = 0;
  int long_hold = 0;
  bit no_idle = 1'b0;

  always #4 clk = ~clk;

  pid_position_delta_controller_unit dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("pid_position_delta_controller_unit_test: errors");
      $finish;
    end
  end

  function automatic longint sat32(input longint v);
    if (v > SatMax) return SatMax;
    if (v < SatMin) return SatMin;
    return v;
  endfunction

  function automatic longint clamp_abs(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Q8.16 gain times Q16.16 signal, floored and saturated.
  function automatic longint gain_mul(input longint g, input longint x);
    return sat32((g * x) >>> 16);
  endfunction

  function automatic drive_beat_t predict_drive(input logic k, input logic signed [31:0] m,
                                                input logic signed [31:0] t, input logic s);
    drive_beat_t res;
    longint raw, err, p, i, d;
    res.drive = '0;
    res.rejected = 1'b0;
    if (k) begin
      integ = 0;
      accum = 0;
      return res;
    end
    raw = longint'(t) - longint'(m);
    if (in_db != 0 && mag(raw) <= in_db) begin
      err = 0;
      integ = 0;
    end else if (s) begin
      err = sat32(((raw * longint'(WSmoothNew)) >>> 16) +
                  ((last_err * longint'(WSmoothOld)) >>> 16));
    end else begin
      err = sat32(raw);
    end
    if (rej_lim != 0 && mag(err) > rej_lim) begin
      res.rejected = 1'b1;
      return res;
    end
    if (!mode_cfg) begin
      p = gain_mul(kp, err);
      d = gain_mul(kd, err - last_err);
      integ = clamp_abs(sat32(integ + gain_mul(ki, err)), int_lim);
      accum = clamp_abs(sat32(p + integ + d), out_lim);
    end else begin
      p = gain_mul(kp, err - last_err);
      i = gain_mul(ki, err);
      d = gain_mul(kd, err - 2 * last_err + older_err);
      integ = i;
      accum = clamp_abs(sat32(accum + p + i + d), out_lim);
    end
    older_err = last_err;
    last_err = err;
    res.drive = (OutDeadband != 0 && mag(accum) < OutDeadband) ? 32'sd0 : accum[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      RegMode:   mode_cfg = val[0];
      RegGainP:  kp = longint'($signed(val[23:0]));
      RegGainI:  ki = longint'($signed(val[23:0]));
      RegGainD:  kd = longint'($signed(val[23:0]));
      RegOutLim: out_lim = longint'(val);
      RegIntLim: int_lim = longint'(val);
      RegInDb:   in_db = longint'(val);
      default:   rej_lim = longint'(val);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup_all(input logic m, input logic [30:0] p, input logic [30:0] i,
                           input logic [30:0] d, input logic [30:0] ol, input logic [30:0] il,
                           input logic [30:0] db, input logic [30:0] rl);
    write_reg(RegMode, {30'd0, m});
    write_reg(RegGainP, p);
    write_reg(RegGainI, i);
    write_reg(RegGainD, d);
    write_reg(RegOutLim, ol);
    write_reg(RegIntLim, il);
    write_reg(RegInDb, db);
    write_reg(RegRejLim, rl);
  endtask

  // Leaves in_valid high after the beat so that a following item can go back to back.
  task automatic send_item(input logic k, input logic signed [31:0] m,
                           input logic signed [31:0] t, input logic s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    measured <= m;
    target <= t;
    smooth <= s;
    do @(posedge clk); while (!in_ready);
    expected_drives.push_back(predict_drive(k, m, t, s));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Result side: random stalls, occasionally a long hold-off.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_drives.size() == 0) begin
        report_mismatch("unexpected beat, drive", drive, 0);
      end else begin
        if (drive !== expected_drives[0].drive)
          report_mismatch("drive", drive, expected_drives[0].drive);
        if (rejected !== expected_drives[0].rejected)
          report_mismatch("rejected", rejected, expected_drives[0].rejected);
        void'(expected_drives.pop_front());
      end
    end
  end

  function automatic logic signed [31:0] rand_signal;
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
  endfunction

  function automatic logic [30:0] rand_gain;
    case ($urandom_range(0, 5))
      0: return 31'h0080_0000;
      1: return 31'h007f_ffff;
      default: return {7'($urandom), 24'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000)};
    endcase
  endfunction

  function automatic logic [30:0] rand_limit;
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom);
      default: return 31'($urandom_range(32'h1_0000, 32'h40_0000));
    endcase
  endfunction

  task automatic test_directed;
    setup_all(1'b0, 31'h1_0000, 31'h4000, 31'h8000, 31'h7fff_ffff, 31'h7fff_ffff, 31'd0, 31'd0);
    send_item(1'b0, 32'sd0, 32'sh0001_0000, 1'b0);
    send_item(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    send_item(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    send_item(1'b0, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_item(1'b0, 32'sh0002_0000, 32'sh8000_0000, 1'b1);
    send_item(1'b1, 32'sh1234_5678, 32'sh8765_4321, 1'b1);
    send_item(1'b0, 32'sh0000_8000, 32'sh0003_0000, 1'b1);
    drain();
    // Deadband hits clear the integral; large errors are rejected.
    write_reg(RegInDb, 31'h0000_4000);
    write_reg(RegRejLim, 31'h0010_0000);
    send_item(1'b0, 32'sd0, 32'sh0000_3000, 1'b0);
    send_item(1'b0, 32'sd0, -32'sh0000_4000, 1'b0);
    send_item(1'b0, 32'sd0, 32'sh0008_0000, 1'b0);
    send_item(1'b0, 32'sd0, 32'sh0020_0000, 1'b1);
    send_item(1'b0, 32'sh0010_0001, 32'sd0, 1'b0);
    drain();
    // Zero limits clamp everything to zero.
    setup_all(1'b0, 31'h007f_ffff, 31'h007f_ffff, 31'h0080_0000, 31'd0, 31'd0, 31'd0, 31'd0);
    send_item(1'b0, 32'sd5, 32'sh0100_0000, 1'b0);
    send_item(1'b0, 32'sh0100_0000, 32'sd5, 1'b1);
    drain();
    setup_all(1'b1, 31'h2_0000, 31'h1000, 31'h7fff_ff80, 31'h0100_0000, 31'h7fff_ffff,
              31'd0, 31'd0);
    send_item(1'b0, 32'sd0, 32'sh0001_0000, 1'b0);
    send_item(1'b0, 32'sd0, 32'sh0003_0000, 1'b1);
    send_item(1'b0, 32'sd0, -32'sh0002_0000, 1'b0);
    send_item(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    send_item(1'b1, 32'sd0, 32'sd0, 1'b0);
    send_item(1'b0, 32'sd0, 32'sh0000_1000, 1'b1);
    drain();
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 8; ph++) begin
      setup_all(1'(ph), rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit(),
                ($urandom_range(0, 2) == 0) ? 31'($urandom_range(0, 32'h2_0000)) : 31'd0,
                ($urandom_range(0, 2) == 0) ? rand_limit() : 31'd0);
      no_idle = (ph == 3);
      for (int n = 0; n < 60; n++)
        send_item($urandom_range(0, 19) == 0, rand_signal(), rand_signal(), 1'($urandom));
      drain();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure;
    setup_all(1'b1, rand_gain(), rand_gain(), rand_gain(), 31'h7fff_ffff, 31'h7fff_ffff,
              31'd0, 31'd0);
    long_hold = 600;
    no_idle = 1'b1;
    for (int n = 0; n < 12; n++)
      send_item(1'b0, rand_signal(), rand_signal(), 1'($urandom));
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    mode_cfg = 1'b0;
    kp = 0; ki = 0; kd = 0;
    out_lim = 0; int_lim = 0; in_db = 0; rej_lim = 0;
    last_err = 0; older_err = 0; integ = 0; accum = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("pid_position_delta_controller_unit_test: clean");
    end else begin
      $display("pid_position_delta_controller_unit_test: errors");
    end
    $finish;
  end
endmodule
